// ===== design/websocket_frame_deframer_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, quiet during reset.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication that also holds across reset.
`define WSFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("deframer reset check failed");

`endif

// ===== design/wsfd_pkg.sv =====
`timescale 1ns / 1ps

package wsfd_pkg;

   // Frame parse phases
   typedef enum logic [2:0] {
      PH_HDR1    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_EXT     = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_STUCK   = 3'd5
   } phase_type;

   // Length codes in the low seven bits of the second header byte
   localparam logic [6:0] LEN_EXT16 = 7'h7e;
   localparam logic [5:0] LEN_EXT_PREFIX = 6'h3f;

   // Byte counts that close the 16-bit and 64-bit extensions and the key
   localparam logic [2:0] EXT16_BYTES = 3'd2;
   localparam logic [2:0] EXT64_WRAP  = 3'd0;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   // One result item
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic       empty_frame;
      logic       framing_error;
   } result_type;

endpackage

// ===== design/wsfd_parser.sv =====
`timescale 1ns / 1ps

module wsfd_parser
   import wsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       result_valid,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  second_header_ff, second_header_in;
   logic [2:0]  byte_counter_ff, byte_counter_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_index_ff, mask_index_in;
   logic [2:0]  count_next;
   logic [7:0]  key_byte;

   // Hold parse state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR1;
         second_header_ff <= '0;
         byte_counter_ff  <= '0;
         remaining_ff     <= '0;
         mask_key_ff      <= '0;
         mask_index_ff    <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         second_header_ff <= second_header_in;
         byte_counter_ff  <= byte_counter_in;
         remaining_ff     <= remaining_in;
         mask_key_ff      <= mask_key_in;
         mask_index_ff    <= mask_index_in;
      end
   end

   assign count_next = byte_counter_ff + 3'd1;

   // Select the key byte for this payload position, key byte 0 on top
   always_comb begin
      case (mask_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Next state and result for the byte at the input
   always_comb begin
      phase_in         = phase_ff;
      second_header_in = second_header_ff;
      byte_counter_in  = byte_counter_ff;
      remaining_in     = remaining_ff;
      mask_key_in      = mask_key_ff;
      mask_index_in    = mask_index_ff;
      result_valid     = 1'b0;
      result           = '0;

      unique case (phase_ff)
         PH_HDR1: begin
            phase_in = PH_HDR2;
         end
         PH_HDR2: begin
            second_header_in = rx_byte;
            byte_counter_in  = '0;
            if (rx_byte[6:1] != LEN_EXT_PREFIX) begin
               remaining_in = {57'd0, rx_byte[6:0]};
               if (!rx_byte[7]) begin
                  phase_in             = PH_STUCK;
                  result_valid         = 1'b1;
                  result.framing_error = 1'b1;
               end else begin
                  phase_in    = PH_KEY;
                  mask_key_in = '0;
               end
            end else begin
               remaining_in = '0;
               phase_in     = PH_EXT;
            end
         end
         PH_EXT: begin
            remaining_in    = {remaining_ff[55:0], rx_byte};
            byte_counter_in = count_next;
            if ((second_header_ff[6:0] == LEN_EXT16) ? (count_next == EXT16_BYTES)
                                                     : (count_next == EXT64_WRAP)) begin
               if (!second_header_ff[7]) begin
                  phase_in             = PH_STUCK;
                  result_valid         = 1'b1;
                  result.framing_error = 1'b1;
               end else begin
                  phase_in        = PH_KEY;
                  byte_counter_in = '0;
                  mask_key_in     = '0;
               end
            end
         end
         PH_KEY: begin
            mask_key_in     = {mask_key_ff[23:0], rx_byte};
            byte_counter_in = count_next;
            if (count_next == KEY_BYTES) begin
               byte_counter_in = '0;
               mask_index_in   = '0;
               if (remaining_ff == 64'd0) begin
                  phase_in             = PH_HDR1;
                  result_valid         = 1'b1;
                  result.last_of_frame = 1'b1;
                  result.empty_frame   = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            mask_index_in       = mask_index_ff + 2'd1;
            remaining_in        = remaining_ff - 64'd1;
            result_valid        = 1'b1;
            result.payload_byte = rx_byte ^ key_byte;
            if (remaining_ff == 64'd1) begin
               phase_in             = PH_HDR1;
               result.last_of_frame = 1'b1;
            end
         end
         default: begin
            // discard everything after a framing error
            phase_in = phase_ff;
         end
      endcase
   end

endmodule

// ===== design/wsfd_out_buf.sv =====
`timescale 1ns / 1ps

module wsfd_out_buf
   import wsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, skid_valid_ff;
   result_type main_ff, skid_ff;
   logic       pop;

   assign pop       = main_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Advance the main slot; park an item in the skid slot while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   // Payload slots carry no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

// ===== design/websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_payload_byte, rsp_last_of_frame,
//                                           rsp_empty_frame, rsp_framing_error
//
// One byte is accepted per cycle while req_ready is high; its result, if any, is registered in the output buffer.
// The frame state updates in the same cycle as the accept, one pass of logic.
// A two-entry output buffer keeps req_ready high until two results wait unread.
// Synchronous reset returns to the first header byte and empties the buffer.
// After a frame without the mask bit, bytes are taken and dropped until reset.

module websocket_frame_deframer_unit
   import wsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame,
   output logic       rsp_framing_error
);

   logic       accept;
   logic       result_valid;
   result_type result;
   result_type out_data;

   assign accept = req_valid & req_ready;

   // Parse and unmask the accepted byte
   wsfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold results until taken
   wsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & result_valid),
      .push_data (result),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_last_of_frame = out_data.last_of_frame;
   assign rsp_empty_frame   = out_data.empty_frame;
   assign rsp_framing_error = out_data.framing_error;

endmodule

// ===== design/wsfd_checker.sv =====
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unit_defines.svh"

module wsfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last_of_frame,
   input logic       rsp_empty_frame,
   input logic       rsp_framing_error
);

   // a stalled result item holds
   `WSFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_last_of_frame) &&
      $stable(rsp_empty_frame) && $stable(rsp_framing_error))

   // a stalled input item holds
   `WSFD_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_rx_byte))

   // a delivered framing error is the last result until reset
   `WSFD_ASSERT_NEXT(a_error_final, clock, reset,
      rsp_valid && rsp_ready && rsp_framing_error, !rsp_valid)

   // input stalls only behind a waiting result
   `WSFD_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid)

   // reset empties the output
   `WSFD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_rx_byte       (req_rx_byte),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_last_of_frame (rsp_last_of_frame),
   .rsp_empty_frame   (rsp_empty_frame),
   .rsp_framing_error (rsp_framing_error)
);

// ===== bench/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;
   import wsfd_pkg::*;

   // Length encodings used when building frames
   typedef enum int {
      FORM_SHORT,
      FORM_EXT16,
      FORM_EXT64
   } len_form_type;

   typedef struct {
      logic [7:0] rx_byte;
      bit         drain;
   } wire_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;
   logic       rsp_framing_error;

   // Bytes waiting to go out, and results the deframer still owes
   wire_byte_type wire_q[$];
   result_type    deframed_q[$];

   int unsigned total_items = 1;
   int unsigned n_sent = 0;
   int unsigned n_frames = 0;
   int unsigned n_payload = 0;
   int unsigned n_empty = 0;
   int unsigned n_errors = 0;
   int unsigned n_fail = 0;
   logic        req_fire = 1'b0;

   // Shadow of the deframer state
   phase_type   st_phase = PH_HDR1;
   logic [7:0]  st_hdr2 = 8'h00;
   logic [2:0]  st_count = 3'd0;
   logic [63:0] st_remaining = 64'd0;
   logic [31:0] st_key = 32'd0;
   logic [1:0]  st_index = 2'd0;

   websocket_frame_deframer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame),
      .rsp_framing_error (rsp_framing_error)
   );

   always #10 clock = ~clock;

   // Queue one expected result
   task automatic owe_result(input logic [7:0] data, input logic last,
                             input logic empty, input logic err);
      result_type r;
      r.payload_byte  = data;
      r.last_of_frame = last;
      r.empty_frame   = empty;
      r.framing_error = err;
      deframed_q.push_back(r);
   endtask

   // Length is complete: check the mask bit, then collect the key
   task automatic close_length();
      if (!st_hdr2[7]) begin
         st_phase = PH_STUCK;
         n_errors++;
         owe_result(8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
         st_phase = PH_KEY;
         st_count = 3'd0;
         st_key   = 32'd0;
      end
   endtask

   // Advance the shadow state by one accepted byte
   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] k;
      case (st_phase)
         PH_HDR1: begin
            st_phase = PH_HDR2;
         end
         PH_HDR2: begin
            st_hdr2      = b;
            st_count     = 3'd0;
            st_remaining = {57'd0, b[6:0]};
            if (b[6:1] == LEN_EXT_PREFIX) begin
               st_remaining = 64'd0;
               st_phase     = PH_EXT;
            end else begin
               close_length();
            end
         end
         PH_EXT: begin
            st_remaining = {st_remaining[55:0], b};
            st_count     = st_count + 3'd1;
            if (st_hdr2[6:0] == LEN_EXT16) begin
               if (st_count == EXT16_BYTES) close_length();
            end else if (st_count == EXT64_WRAP) begin
               close_length();
            end
         end
         PH_KEY: begin
            st_key   = {st_key[23:0], b};
            st_count = st_count + 3'd1;
            if (st_count == KEY_BYTES) begin
               st_count = 3'd0;
               st_index = 2'd0;
               if (st_remaining == 64'd0) begin
                  st_phase = PH_HDR1;
                  n_empty++;
                  owe_result(8'h00, 1'b1, 1'b1, 1'b0);
               end else begin
                  st_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            k            = st_key[8 * (3 - st_index) +: 8];
            st_index     = st_index + 2'd1;
            st_remaining = st_remaining - 64'd1;
            n_payload++;
            if (st_remaining == 64'd0) begin
               st_phase = PH_HDR1;
               owe_result(b ^ k, 1'b1, 1'b0, 1'b0);
            end else begin
               owe_result(b ^ k, 1'b0, 1'b0, 1'b0);
            end
         end
         default: begin
            // discard phase: drop the byte
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b, input bit drain);
      wire_byte_type w;
      w.rx_byte = b;
      w.drain   = drain;
      wire_q.push_back(w);
   endtask

   // Build one frame: header, length extension, and key and payload when masked
   task automatic add_frame(input logic [7:0] hdr1, input len_form_type form,
                            input logic [63:0] len, input bit masked,
                            input logic [31:0] key, input bit drain);
      logic [6:0]  len7;
      longint unsigned j;
      len7 = (form == FORM_SHORT) ? len[6:0] :
             (form == FORM_EXT16) ? LEN_EXT16 : {LEN_EXT_PREFIX, 1'b1};
      n_frames++;
      push_byte(hdr1, drain);
      push_byte({masked, len7}, 1'b0);
      if (form == FORM_EXT16) begin
         push_byte(len[15:8], 1'b0);
         push_byte(len[7:0], 1'b0);
      end else if (form == FORM_EXT64) begin
         for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8], 1'b0);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8], 1'b0);
         for (j = 0; j < len; j++) push_byte(8'($urandom), 1'b0);
      end
   endtask

   // Mostly short payloads, a few empty, a few of 100 to 300 bytes (up to 125 in the short form)
   function automatic logic [63:0] pick_len(input len_form_type form);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 64'd0;
      if (r < 90) return 64'($urandom_range(12, 1));
      case (form)
         FORM_SHORT: return (r >= 97) ? 64'd125 : 64'($urandom_range(125, 100));
         FORM_EXT16: return 64'($urandom_range(300, 126));
         default:    return 64'($urandom_range(200, 126));
      endcase
   endfunction

   // Check results against the oldest expectation, then predict
   always @(posedge clock) begin : check_results
      result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               $error("unexpected result item: payload_byte %02h last %0b empty %0b err %0b",
                      rsp_payload_byte, rsp_last_of_frame, rsp_empty_frame,
                      rsp_framing_error);
               n_fail++;
            end else begin
               want = deframed_q.pop_front();
               if (rsp_payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %02h, actual %02h",
                         want.payload_byte, rsp_payload_byte);
                  n_fail++;
               end
               if (rsp_last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0b, actual %0b",
                         want.last_of_frame, rsp_last_of_frame);
                  n_fail++;
               end
               if (rsp_empty_frame !== want.empty_frame) begin
                  $error("empty_frame: expected %0b, actual %0b",
                         want.empty_frame, rsp_empty_frame);
                  n_fail++;
               end
               if (rsp_framing_error !== want.framing_error) begin
                  $error("framing_error: expected %0b, actual %0b",
                         want.framing_error, rsp_framing_error);
                  n_fail++;
               end
            end
         end
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
   end

   // Present bytes and throttle the result side at the falling edge
   always @(negedge clock) begin : drive_bytes
      int unsigned stage;
      int unsigned tx_idle;
      int unsigned rx_idle;
      stage   = (n_sent * 3) / total_items;
      tx_idle = (stage == 0) ? 30 : (stage == 1) ? 71 : 0;
      rx_idle = (stage == 0) ? 71 : (stage == 1) ? 30 : 0;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= rx_idle);
         if (!req_valid || req_fire) begin
            if (wire_q.size() != 0 && !(wire_q[0].drain && deframed_q.size() != 0) &&
                $urandom_range(99) >= tx_idle) begin
               req_valid   <= 1'b1;
               req_rx_byte <= wire_q[0].rx_byte;
               void'(wire_q.pop_front());
               n_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin : run_limit
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned  directed_count;
      len_form_type form;
      int unsigned  r;
      bit           first;

      // Directed: extremes of header and key, each length form, empty frame
      add_frame(8'hff, FORM_SHORT, 64'd1, 1'b1, 32'hffff_ffff, 1'b0);
      add_frame(8'h00, FORM_EXT16, 64'd0, 1'b1, 32'h0000_0000, 1'b0);
      add_frame(8'h81, FORM_EXT64, 64'd1, 1'b1, 32'ha55a_c33c, 1'b0);
      directed_count = wire_q.size();

      // Random well-formed frames; hold off the first until the pipe drains
      first = 1'b1;
      while (wire_q.size() < directed_count + 500) begin
         r = $urandom_range(99);
         form = (r < 60) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
         add_frame(8'($urandom), form, pick_len(form), 1'b1, $urandom, first);
         first = 1'b0;
      end

      // Mask bit clear with a huge 64-bit length, then noise that gets dropped
      add_frame(8'($urandom), FORM_EXT64, {1'b1, 31'($urandom), 32'($urandom)},
                1'b0, 32'd0, 1'b1);
      repeat (8) push_byte(8'($urandom), 1'b0);
      total_items = wire_q.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (wire_q.size() != 0 || req_valid || deframed_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d frames under three throttle mixes.",
               n_sent, n_frames);
      $display("Checked %0d payload bytes, %0d empty frames, %0d framing errors.",
               n_payload, n_empty, n_errors);
      if (n_fail == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
